[hdl/lcp_pkg.sv]
// Shared types, codes and constants of the letter/code command parser.
package lcp_pkg;

	localparam int PARAM_SLOTS_DEF = 4;
	localparam int VALUE_BITS_DEF  = 16;
	localparam int NUM_PARAM_OUT   = 4;
	localparam int FIELD_W         = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0] CH_LF      = 8'd10;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_SP      = 8'd32;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CASE_SHIFT = 8'd32;
	localparam logic [6:0] LETTER_RST = 7'd95;

	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_RESTART = 2'd1;
	localparam logic [1:0] KIND_NOPROC  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
	} cmd_t;

	typedef struct packed {
		logic        ready_res;
		logic [2:0]  parse_phase;
		logic [2:0]  error_kind;
		logic [6:0]  cmd_letter;
		logic [15:0] cmd_code;
		logic [2:0]  param_total;
		logic [15:0] param_a;
		logic [15:0] param_b;
		logic [15:0] param_c;
		logic [15:0] param_d;
	} res_t;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_RESTART,
		OP_NOPROC,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		CC_LETTER,
		CC_DIGIT,
		CC_LF,
		CC_CR,
		CC_BLANK,
		CC_OTHER
	} cls_t;

	typedef struct packed {
		op_t        op;
		cls_t       cls;
		logic [3:0] digit;
		logic [6:0] letter;
	} item_t;

	typedef struct packed {
		logic not_empty;
		logic not_full;
	} q_stat_t;

	typedef enum logic [2:0] {
		PH_INIT  = 3'd0,
		PH_CODE  = 3'd1,
		PH_PPOSS = 3'd2,
		PH_PARAM = 3'd3,
		PH_OK    = 3'd4,
		PH_ERROR = 3'd5,
		PH_FLUSH = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ER_NONE   = 3'd0,
		ER_CHAR   = 3'd1,
		ER_CODE   = 3'd2,
		ER_PARAM  = 3'd3,
		ER_NOPROC = 3'd4
	} err_t;

endpackage

[hdl/letter_code_command_parser_core.sv]
// Letter/code command parser: top level.
//
// Usage: each request on cmd carries one kind and one byte of an ASCII
// command line. kind 0 feeds a byte, 1 restarts the parser, 2 marks the
// line as not processable. Every accepted request gives exactly one
// result on res: the parser state after that request (letter, code,
// parameters, phase, error, ready flag).
// Both channels use valid/ready; a transfer happens when both are high.
// Path: a request is first written into the queue and, once popped, is
// loaded into the parser's result register.
// Throughput: one request per cycle while res_ready stays high, set by
// the back-end parser state updating on every pop; a two-entry queue
// separates the byte classifier from the parser.
// Stalls: while res_ready is low the result holds, the queue fills, and
// cmd_ready drops once both queue entries are taken.
// Reset: arst_n clears the parser to the init phase, letter '_', all
// values zero, and empties the queue; no result is pending after reset.
module letter_code_command_parser_core import lcp_pkg::*; #(
	parameter int PARAM_SLOTS = PARAM_SLOTS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	q_stat_t q_stat;
	logic    push;
	item_t   push_item;
	logic    pop;
	item_t   pop_item;

	lcp_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	lcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	lcp_back #(
		.PARAM_SLOTS (PARAM_SLOTS),
		.VALUE_BITS  (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_item  (pop_item),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

[hdl/lcp_front.sv]
// Front end: accepts requests and classifies each received byte.
module lcp_front import lcp_pkg::*; (
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  cmd_t    cmd,
	input  q_stat_t q_stat,
	output logic    push,
	output item_t   push_item
);

	logic [7:0] up_byte;

	assign cmd_ready = q_stat.not_full;
	assign push      = cmd_valid && q_stat.not_full;

	always_comb begin
		up_byte = cmd.rx_byte;
		if (cmd.rx_byte inside {[8'd97:8'd122]}) begin
			up_byte = cmd.rx_byte - CASE_SHIFT;
		end

		case (cmd.kind)
			KIND_BYTE:    push_item.op = OP_BYTE;
			KIND_RESTART: push_item.op = OP_RESTART;
			KIND_NOPROC:  push_item.op = OP_NOPROC;
			default:      push_item.op = OP_NOP;
		endcase

		if (up_byte inside {[8'd65:8'd90]}) begin
			push_item.cls = CC_LETTER;
		end else if (cmd.rx_byte inside {[8'd48:8'd57]}) begin
			push_item.cls = CC_DIGIT;
		end else if (cmd.rx_byte == CH_LF) begin
			push_item.cls = CC_LF;
		end else if (cmd.rx_byte == CH_CR) begin
			push_item.cls = CC_CR;
		end else if (cmd.rx_byte == CH_SP || cmd.rx_byte == CH_TAB) begin
			push_item.cls = CC_BLANK;
		end else begin
			push_item.cls = CC_OTHER;
		end

		push_item.digit  = 4'(cmd.rx_byte - CH_ZERO);
		push_item.letter = up_byte[6:0];
	end

endmodule

[hdl/lcp_queue.sv]
// Two-entry queue of classified items between front and back end.
module lcp_queue import lcp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   pop_item,
	output q_stat_t q_stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_item         = entry_q[rd_ptr_q];
	assign q_stat.not_empty = (count_q != '0);
	assign q_stat.not_full  = (count_q != CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/lcp_back.sv]
// Back end: line parser state machine and result register.
module lcp_back import lcp_pkg::*; #(
	parameter int PARAM_SLOTS = PARAM_SLOTS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  item_t   pop_item,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_ready,
	output res_t    res
);

	localparam int CNT_W = $clog2(PARAM_SLOTS + 1);
	localparam int SUM_W = VALUE_BITS + 4;

	phase_t                phase_q, phase_d;
	err_t                  err_q, err_d;
	logic [6:0]            letter_q, letter_d;
	logic [VALUE_BITS-1:0] code_q, code_d;
	logic [VALUE_BITS-1:0] prm_q [PARAM_SLOTS];
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  res_valid_q;

	logic                  prm_wr;
	logic                  prm_clr;
	logic [VALUE_BITS-1:0] prm_wr_val;
	logic [VALUE_BITS-1:0] cur_prm;
	logic [SUM_W-1:0]      code_sum;
	logic [SUM_W-1:0]      prm_sum;
	logic                  code_ovf;
	logic                  prm_ovf;
	logic [FIELD_W-1:0]    slot_out [NUM_PARAM_OUT];

	assign pop       = q_stat.not_empty && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;

	always_comb begin
		cur_prm = '0;
		for (int i = 0; i < PARAM_SLOTS; i++) begin
			if (count_q == CNT_W'(i)) begin
				cur_prm = prm_q[i];
			end
		end
		code_sum = (SUM_W'(code_q) << 3) + (SUM_W'(code_q) << 1) + SUM_W'(pop_item.digit);
		prm_sum  = (SUM_W'(cur_prm) << 3) + (SUM_W'(cur_prm) << 1) + SUM_W'(pop_item.digit);
		code_ovf = |code_sum[SUM_W-1:VALUE_BITS];
		prm_ovf  = |prm_sum[SUM_W-1:VALUE_BITS];
	end

	always_comb begin
		phase_d    = phase_q;
		err_d      = err_q;
		letter_d   = letter_q;
		code_d     = code_q;
		count_d    = count_q;
		prm_wr     = 1'b0;
		prm_clr    = 1'b0;
		prm_wr_val = prm_sum[VALUE_BITS-1:0];

		case (pop_item.op)
			OP_RESTART: begin
				phase_d  = PH_INIT;
				err_d    = ER_NONE;
				letter_d = LETTER_RST;
				code_d   = '0;
				count_d  = '0;
				prm_clr  = 1'b1;
			end
			OP_NOPROC: begin
				phase_d = PH_ERROR;
				err_d   = ER_NOPROC;
			end
			OP_BYTE: begin
				case (phase_q)
					PH_FLUSH: begin
						if (pop_item.cls == CC_LF) begin
							phase_d = PH_ERROR;
						end
					end
					PH_INIT: begin
						if (pop_item.cls == CC_LETTER) begin
							letter_d = pop_item.letter;
							phase_d  = PH_CODE;
						end else if (pop_item.cls != CC_LF && pop_item.cls != CC_BLANK) begin
							phase_d = PH_FLUSH;
							err_d   = ER_CHAR;
						end
					end
					PH_CODE: begin
						case (pop_item.cls)
							CC_DIGIT: begin
								if (code_ovf) begin
									phase_d = PH_FLUSH;
									err_d   = ER_CODE;
								end else begin
									code_d = code_sum[VALUE_BITS-1:0];
								end
							end
							CC_LF:    phase_d = PH_OK;
							CC_CR:    phase_d = PH_CODE;
							CC_BLANK: phase_d = PH_PPOSS;
							default: begin
								phase_d = PH_FLUSH;
								err_d   = ER_CHAR;
							end
						endcase
					end
					PH_PPOSS: begin
						case (pop_item.cls)
							CC_DIGIT: begin
								if (count_q < CNT_W'(PARAM_SLOTS)) begin
									prm_wr     = 1'b1;
									prm_wr_val = VALUE_BITS'(pop_item.digit);
									phase_d    = PH_PARAM;
								end else begin
									phase_d = PH_FLUSH;
									err_d   = ER_PARAM;
								end
							end
							CC_LF:    phase_d = PH_OK;
							CC_BLANK: phase_d = PH_PPOSS;
							default: begin
								phase_d = PH_FLUSH;
								err_d   = ER_CHAR;
							end
						endcase
					end
					PH_PARAM: begin
						case (pop_item.cls)
							CC_DIGIT: begin
								if (prm_ovf) begin
									phase_d = PH_FLUSH;
									err_d   = ER_PARAM;
								end else begin
									prm_wr = 1'b1;
								end
							end
							CC_LF: begin
								count_d = count_q + 1'b1;
								phase_d = PH_OK;
							end
							CC_CR: phase_d = PH_PARAM;
							CC_BLANK: begin
								count_d = count_q + 1'b1;
								phase_d = PH_PPOSS;
							end
							default: begin
								phase_d = PH_FLUSH;
								err_d   = ER_CHAR;
							end
						endcase
					end
					default: phase_d = phase_q;
				endcase
			end
			default: phase_d = phase_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INIT;
			err_q       <= ER_NONE;
			letter_q    <= LETTER_RST;
			code_q      <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q  <= phase_d;
				err_q    <= err_d;
				letter_q <= letter_d;
				code_q   <= code_d;
				count_q  <= count_d;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PARAM_SLOTS; i++) begin
				prm_q[i] <= '0;
			end
		end else if (pop) begin
			for (int i = 0; i < PARAM_SLOTS; i++) begin
				if (prm_clr) begin
					prm_q[i] <= '0;
				end else if (prm_wr && count_q == CNT_W'(i)) begin
					prm_q[i] <= prm_wr_val;
				end
			end
		end
	end

	for (genvar g = 0; g < NUM_PARAM_OUT; g++) begin : g_slot
		if (g < PARAM_SLOTS) begin : g_used
			assign slot_out[g] = FIELD_W'(prm_q[g]);
		end else begin : g_unused
			assign slot_out[g] = '0;
		end
	end

	always_comb begin
		res.ready_res   = (phase_q == PH_OK) || (phase_q == PH_ERROR);
		res.parse_phase = (phase_q == PH_FLUSH) ? PH_ERROR : phase_q;
		res.error_kind  = err_q;
		res.cmd_letter  = letter_q;
		res.cmd_code    = FIELD_W'(code_q);
		res.param_total = 3'(count_q);
		res.param_a     = slot_out[0];
		res.param_b     = slot_out[1];
		res.param_c     = slot_out[2];
		res.param_d     = slot_out[3];
	end

endmodule

[hdl/lcp_checker.sv]
// Port-level assertions for the command parser, bound to the top level.
module lcp_checker import lcp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input cmd_t cmd,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("request changed while stalled");

	a_ready_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.ready_res |->
		res.parse_phase == PH_OK || res.parse_phase == PH_ERROR)
		else $error("ready flag outside ok or error phase");

	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.error_kind != ER_NONE) == (res.parse_phase == PH_ERROR))
		else $error("error code and error phase disagree");

	a_init_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.parse_phase == PH_INIT |->
		res.cmd_letter == LETTER_RST && res.cmd_code == '0 && res.param_total == '0)
		else $error("init phase with parsed content");

endmodule

bind letter_code_command_parser_core lcp_checker u_lcp_checker (.*);

[dv/lcp_line_checker.sv]
// Checker for the command parser: predicts each result and compares it with the block's output.
`timescale 1ns / 1ps

module lcp_line_checker import lcp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_ready,
	input  cmd_t cmd,
	input  logic res_valid,
	input  logic res_ready,
	input  res_t res,
	output int   mismatches,
	output int   pending
);

	localparam int unsigned VALUE_MAX = (1 << VALUE_BITS_DEF) - 1;

	phase_t      st_phase;
	err_t        st_err;
	logic [6:0]  st_letter;
	logic [15:0] st_code;
	logic [15:0] st_param [NUM_PARAM_OUT];
	logic [2:0]  st_count;

	res_t expected_states [$];

	function automatic bit is_digit(logic [7:0] ch);
		return ch >= CH_ZERO && ch <= CH_ZERO + 8'd9;
	endfunction

	function automatic bit is_blank(logic [7:0] ch);
		return ch == CH_SP || ch == CH_TAB;
	endfunction

	function automatic void enter_flush(err_t e);
		st_phase = PH_FLUSH;
		st_err = e;
	endfunction

	function automatic void clear_line();
		st_phase = PH_INIT;
		st_err = ER_NONE;
		st_letter = LETTER_RST;
		st_code = '0;
		st_count = '0;
		for (int i = 0; i < NUM_PARAM_OUT; i++)
			st_param[i] = '0;
	endfunction

	// Applies one request to the parser state and returns the state seen afterwards.
	function automatic res_t parse_request(cmd_t c);
		res_t        r;
		logic [7:0]  ch;
		logic [1:0]  slot;
		int unsigned acc;
		ch = c.rx_byte;
		slot = st_count[1:0];
		case (op_t'(c.kind))
			OP_BYTE: begin
				case (st_phase)
					PH_FLUSH: begin
						if (ch == CH_LF)
							st_phase = PH_ERROR;
					end
					PH_INIT: begin
						if (ch >= "a" && ch <= "z")
							ch = ch - CASE_SHIFT;
						if (ch >= "A" && ch <= "Z") begin
							st_letter = ch[6:0];
							st_phase = PH_CODE;
						end else if (!(ch == CH_LF || is_blank(ch))) begin
							enter_flush(ER_CHAR);
						end
					end
					PH_CODE: begin
						if (is_digit(ch)) begin
							acc = 32'(st_code) * 10 + 32'(ch - CH_ZERO);
							if (acc > VALUE_MAX)
								enter_flush(ER_CODE);
							else
								st_code = acc[15:0];
						end else if (ch == CH_LF) begin
							st_phase = PH_OK;
						end else if (ch == CH_CR) begin
						end else if (is_blank(ch)) begin
							st_phase = PH_PPOSS;
						end else begin
							enter_flush(ER_CHAR);
						end
					end
					PH_PPOSS: begin
						if (is_digit(ch)) begin
							if (st_count < PARAM_SLOTS_DEF) begin
								st_param[slot] = 16'(ch - CH_ZERO);
								st_phase = PH_PARAM;
							end else begin
								enter_flush(ER_PARAM);
							end
						end else if (ch == CH_LF) begin
							st_phase = PH_OK;
						end else if (!is_blank(ch)) begin
							enter_flush(ER_CHAR);
						end
					end
					PH_PARAM: begin
						if (is_digit(ch)) begin
							acc = 32'(st_param[slot]) * 10 + 32'(ch - CH_ZERO);
							if (acc > VALUE_MAX)
								enter_flush(ER_PARAM);
							else
								st_param[slot] = acc[15:0];
						end else if (ch == CH_LF) begin
							st_count = st_count + 3'd1;
							st_phase = PH_OK;
						end else if (ch == CH_CR) begin
						end else if (is_blank(ch)) begin
							st_count = st_count + 3'd1;
							st_phase = PH_PPOSS;
						end else begin
							enter_flush(ER_CHAR);
						end
					end
					default: begin
					end
				endcase
			end
			OP_RESTART: clear_line();
			OP_NOPROC: begin
				st_err = ER_NOPROC;
				st_phase = PH_ERROR;
			end
			default: begin
			end
		endcase
		r.ready_res = st_phase == PH_OK || st_phase == PH_ERROR;
		r.parse_phase = (st_phase == PH_FLUSH) ? PH_ERROR : st_phase;
		r.error_kind = st_err;
		r.cmd_letter = st_letter;
		r.cmd_code = st_code;
		r.param_total = st_count;
		r.param_a = st_param[0];
		r.param_b = st_param[1];
		r.param_c = st_param[2];
		r.param_d = st_param[3];
		return r;
	endfunction

	task automatic note_field(string nm, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			if (mismatches < 10)
				$display("%0t: %s expected %0d, got %0d", $time, nm, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			clear_line();
			expected_states.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_states.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with no request outstanding", $time);
					mismatches++;
				end else begin
					want = expected_states.pop_front();
					note_field("ready_res", 16'(want.ready_res), 16'(res.ready_res));
					note_field("parse_phase", 16'(want.parse_phase), 16'(res.parse_phase));
					note_field("error_kind", 16'(want.error_kind), 16'(res.error_kind));
					note_field("cmd_letter", 16'(want.cmd_letter), 16'(res.cmd_letter));
					note_field("cmd_code", want.cmd_code, res.cmd_code);
					note_field("param_total", 16'(want.param_total), 16'(res.param_total));
					note_field("param_a", want.param_a, res.param_a);
					note_field("param_b", want.param_b, res.param_b);
					note_field("param_c", want.param_c, res.param_c);
					note_field("param_d", want.param_d, res.param_d);
				end
			end
			if (cmd_valid && cmd_ready)
				expected_states.push_back(parse_request(cmd));
			pending <= expected_states.size();
		end
	end

endmodule

[dv/letter_code_command_parser_core_test.sv]
// Testbench top for the command parser: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module letter_code_command_parser_core_test;
	import lcp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	int   mismatches;
	int   pending;

	bit         idle_on = 1'b1;
	int         stall_left = 0;
	int         sent = 0;
	logic [7:0] line_bytes [$];

	letter_code_command_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	lcp_line_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic int unsigned pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(0, 99);
		else if (r < 80)
			return $urandom_range(0, 65535);
		else if (r < 90)
			return 65535;
		else
			return $urandom_range(65536, 999999);
	endfunction

	function automatic logic [7:0] pick_blank();
		return $urandom_range(0, 1) ? CH_SP : CH_TAB;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	task automatic send(op_t k, logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{kind: k, rx_byte: b};
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sent++;
	endtask

	task automatic append_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endtask

	task automatic send_line();
		while (line_bytes.size() != 0)
			send(OP_BYTE, line_bytes.pop_front());
	endtask

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int         directed_end;
		int         r;
		int         nparams;
		logic [7:0] base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown kind, blanks, empty line, lower case, CR in code, end after blanks
		send(OP_NOP, 8'hFF);
		append_text("\n\tg1\r  \n");
		send_line();
		send(OP_BYTE, 8'hFF);
		send(OP_BYTE, 8'h00);
		// code overflow
		send(OP_RESTART, 8'h00);
		append_text("M65536\n");
		send_line();
		// CR before the letter is an invalid char
		send(OP_RESTART, 8'hA5);
		append_text("\r");
		send_line();
		send(OP_NOPROC, 8'h5A);
		directed_end = sent;

		while (sent < directed_end + 400) begin
			if ($urandom_range(0, 19) == 0)
				idle_on = !idle_on;
			r = $urandom_range(0, 99);
			if (r < 75) begin
				if ($urandom_range(0, 9) != 0)
					send(OP_RESTART, 8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_blank());
				base = $urandom_range(0, 1) ? "a" : "A";
				line_bytes.push_back(base + 8'($urandom_range(0, 25)));
				if ($urandom_range(0, 9) != 0)
					append_text($sformatf("%0d", pick_value()));
				if ($urandom_range(0, 7) == 0)
					line_bytes.push_back(CH_CR);
				nparams = $urandom_range(0, 5);
				for (int i = 0; i < nparams; i++) begin
					repeat ($urandom_range(1, 2)) line_bytes.push_back(pick_blank());
					if ($urandom_range(0, 9) == 0)
						append_text("0");
					append_text($sformatf("%0d", pick_value()));
					if ($urandom_range(0, 9) == 0)
						line_bytes.push_back(CH_CR);
				end
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 2)) line_bytes.push_back(pick_blank());
				if ($urandom_range(0, 19) == 0)
					line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
						8'($urandom_range(0, 255));
				line_bytes.push_back(CH_LF);
				send_line();
			end else if (r < 83) begin
				send(OP_RESTART, 8'($urandom_range(0, 255)));
			end else if (r < 88) begin
				send(OP_NOPROC, 8'($urandom_range(0, 255)));
			end else if (r < 92) begin
				send(OP_NOP, 8'($urandom_range(0, 255)));
			end else begin
				send(OP_BYTE, 8'($urandom_range(0, 255)));
			end
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
